[hw/rtl/prime_sieve_bitmap_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the prime sieve bitmap core
// Concurrent checks that compile out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PRIME_SIEVE_BITMAP_CORE_ASSERT_SVH
`define PRIME_SIEVE_BITMAP_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PSB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("psb assertion failed");
`define PSB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("psb assertion failed");
`else
`define PSB_ASSERT(lbl, clk, rst_n, prop)
`define PSB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hw/rtl/psb_pkg.sv]
// ---------------------------------------------------------------------------
// psb_pkg
// Types and constants shared by the prime sieve bitmap core.
// ---------------------------------------------------------------------------
package psb_pkg;

    localparam int unsigned MAX_N_DEF = 65535;

    localparam logic MODE_BUILD = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic is_prime;
        logic built_done;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_CHECK,
        ST_CLEAR
    } t_state;

endpackage

[hw/rtl/psb_ram.sv]
// ---------------------------------------------------------------------------
// psb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module psb_ram #(
    parameter int W = 1,
    parameter int D = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/prime_sieve_bitmap_core.sv]
// ---------------------------------------------------------------------------
// prime_sieve_bitmap_core
// One-bit primality map over 0..MAX_N, built by an odd-only sieve in RAM.
// ---------------------------------------------------------------------------
// Usage: raise start with an item while busy is low; the item is taken at
// that edge. mode = build fills the map, mode = query reads one value.
// Every item gives one result on o_result, marked by o_valid for one cycle.
// Query: one map read each, with the result in the cycle after the item is
// taken; busy stays low, so a query may be issued every cycle. A value above
// MAX_N, or any query before the first build, returns is_prime = 0.
// Build: busy is high while the map is filled (ST_FILL), then for each odd
// i with i*i <= MAX_N its bit is read (ST_READ, ST_CHECK) and, if still set,
// its multiples from i*i on are cleared (ST_CLEAR). The result, with
// built_done set, appears in the cycle busy falls.
// Reset: the sequencer goes idle and the map is marked not built; the RAM
// content is left as is and every build rewrites all of it.
// The receiver cannot stall: results are taken in the cycle they appear.
// ---------------------------------------------------------------------------
`include "prime_sieve_bitmap_core_assert.svh"

module prime_sieve_bitmap_core #(
    parameter int unsigned MAX_N = psb_pkg::MAX_N_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  psb_pkg::t_in_item   i_item,
    output logic                busy,
    output logic                o_valid,
    output psb_pkg::t_out_item  o_result
);

    import psb_pkg::*;

    localparam int AW = $clog2(MAX_N + 1);
    localparam int SW = AW + 2;
    localparam logic [AW-1:0] TOP_A = AW'(MAX_N);
    localparam logic [SW-1:0] TOP_S = SW'(MAX_N);

    t_state        r_state, n_state;
    logic [AW-1:0] r_a, n_a;
    logic [SW-1:0] r_i, n_i;
    logic [SW-1:0] r_sq, n_sq;
    logic [SW-1:0] r_j, n_j;
    logic          r_map_valid, n_map_valid;
    logic          r_bdone, n_bdone;
    logic          r_qv, n_qv;
    logic          r_qok, n_qok;

    logic          w_accept;
    logic          w_in_range;
    logic [SW-1:0] w_i_next;
    logic [SW-1:0] w_sq_next;
    logic [SW-1:0] w_j_next;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_wdata;
    logic [AW-1:0] w_raddr;
    logic          w_rdata;

    assign busy       = (r_state != ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_in_range = (32'(i_item.value) <= 32'(MAX_N));
    assign w_i_next   = r_i + SW'(2);
    assign w_sq_next  = r_sq + {r_i[SW-3:0], 2'b00} + SW'(4);
    assign w_j_next   = r_j + r_i;

    psb_ram #(
        .W (1),
        .D (MAX_N + 1)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_i         = r_i;
        n_sq        = r_sq;
        n_j         = r_j;
        n_map_valid = r_map_valid;
        n_bdone     = 1'b0;
        n_qv        = 1'b0;
        n_qok       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_item.mode == MODE_BUILD) begin
                        n_state = ST_FILL;
                        n_a     = '0;
                    end else begin
                        n_qv  = 1'b1;
                        n_qok = r_map_valid && w_in_range;
                    end
                end
            end
            ST_FILL: begin
                if (r_a == TOP_A) begin
                    n_state = ST_READ;
                    n_i     = SW'(3);
                    n_sq    = SW'(9);
                end else begin
                    n_a = r_a + AW'(1);
                end
            end
            ST_READ: begin
                if (r_sq > TOP_S) begin
                    n_state     = ST_IDLE;
                    n_map_valid = 1'b1;
                    n_bdone     = 1'b1;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_rdata) begin
                    n_state = ST_CLEAR;
                    n_j     = r_sq;
                end else begin
                    n_state = ST_READ;
                    n_i     = w_i_next;
                    n_sq    = w_sq_next;
                end
            end
            ST_CLEAR: begin
                if (w_j_next > TOP_S) begin
                    n_state = ST_READ;
                    n_i     = w_i_next;
                    n_sq    = w_sq_next;
                end else begin
                    n_j = w_j_next;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_a;
        w_wdata = 1'b0;
        w_raddr = AW'(i_item.value);
        case (r_state)
            ST_FILL: begin
                w_we    = 1'b1;
                w_wdata = (r_a == AW'(2)) || ((r_a >= AW'(3)) && r_a[0]);
            end
            ST_READ: begin
                w_raddr = r_i[AW-1:0];
            end
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_j[AW-1:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_map_valid <= 1'b0;
            r_bdone     <= 1'b0;
            r_qv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map_valid <= n_map_valid;
            r_bdone     <= n_bdone;
            r_qv        <= n_qv;
        end
        r_a   <= n_a;
        r_i   <= n_i;
        r_sq  <= n_sq;
        r_j   <= n_j;
        r_qok <= n_qok;
    end

    assign o_valid             = r_qv || r_bdone;
    assign o_result.is_prime   = r_qv && r_qok && w_rdata;
    assign o_result.built_done = r_bdone;

    `PSB_ASSERT(a_single_result, i_clk, i_rst_n, !(r_qv && r_bdone))
    `PSB_ASSERT(a_done_sets_valid, i_clk, i_rst_n, r_bdone |-> r_map_valid && !busy)
    `PSB_ASSERT(a_build_goes_busy, i_clk, i_rst_n,
                (w_accept && (i_item.mode == MODE_BUILD)) |=> busy)
    `PSB_ASSERT(a_no_query_in_build, i_clk, i_rst_n, (busy && $past(busy)) |-> !r_qv)

endmodule
